[hdl/dmsp_pkg.sv]
// Shared types and constants of the dual motor speed PID block.
// No dependencies; every module in hdl/ imports this package.
package dmsp_pkg;

	localparam int DUTY_BITS = 12;
	localparam int CFG_W     = 31;
	localparam int IDX_W     = 3;
	localparam int NUM_W     = 56;
	localparam int DEN_W     = 32;
	localparam int CNT_W     = $clog2(NUM_W + 1);

	localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [IDX_W-1:0] REG_INT_GAIN   = 3'd1;
	localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [IDX_W-1:0] REG_WINDUP     = 3'd3;
	localparam logic [IDX_W-1:0] REG_DUTY_MAX   = 3'd4;
	localparam logic [IDX_W-1:0] REG_PPR        = 3'd5;

	localparam logic [1:0] DIR_COAST = 2'd0;
	localparam logic [1:0] DIR_FWD   = 2'd1;
	localparam logic [1:0] DIR_REV   = 2'd2;

	// 60000 ms/min times 256 (Q.8)
	localparam logic [23:0] RPM_SCALE = 24'd15360000;
	localparam logic [9:0]  MS_PER_S  = 10'd1000;
	localparam logic [15:0] DUTY_CEIL = 16'((1 << DUTY_BITS) - 1);
	// ceil(2^40 / 1000); (n * RECIP_1000) >> 40 is exact for any n below 2^30
	localparam logic [30:0] RECIP_1000 = 31'd1099511628;

	typedef struct packed {
		logic [23:0] prop_gain;
		logic [23:0] integral_gain;
		logic [23:0] deriv_gain;
		logic [30:0] windup_limit;
		logic [11:0] duty_max;
		logic [15:0] pulses_per_rev;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic ack;
	} lane_cmd_t;

endpackage

[hdl/dmsp_div.sv]
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on dmsp_pkg for operand widths.
module dmsp_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [dmsp_pkg::NUM_W-1:0] num,
	input  logic [dmsp_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [dmsp_pkg::NUM_W-1:0] quo
);
	import dmsp_pkg::*;

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W+1:0] trial;

	assign trial = {1'b0, rem_q, quo_q[NUM_W-1]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			if (!trial[DEN_W+1]) begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DEN_W-2:0], quo_q[NUM_W-1]};
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[hdl/dmsp_lane.sv]
// One wheel: speed from count delta, PID with windup clamp, duty and direction.
// Depends on dmsp_pkg and dmsp_div.
module dmsp_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dmsp_pkg::cfg_t                cfg,
	input  dmsp_pkg::lane_cmd_t           cmd,
	input  logic signed [31:0]            count,
	input  logic signed [23:0]            target,
	input  logic [15:0]                   dt,
	output logic                          done,
	output logic [dmsp_pkg::DUTY_BITS-1:0] duty,
	output logic [1:0]                    dir,
	output logic signed [23:0]            speed
);
	import dmsp_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_PREP = 9'b000000010,
		S_DSP  = 9'b000000100,
		S_ERR  = 9'b000001000,
		S_PROD = 9'b000010000,
		S_DINT = 9'b000100000,
		S_DDER = 9'b001000000,
		S_MAC  = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t state_q;

	logic signed [31:0] last_count_q;
	logic signed [31:0] integ_q;
	logic signed [24:0] lerr_q;
	logic signed [31:0] delta_q;
	logic signed [23:0] target_q;
	logic [15:0]        dt_q;
	logic signed [23:0] sp_q;
	logic signed [24:0] err_q;
	logic signed [39:0] dv_q;
	logic signed [63:0] acc_q;
	logic [NUM_W-1:0]   dnum_q;
	logic [DEN_W-1:0]   dden_q;
	logic               neg_q;
	logic               div_start_q;
	logic [2:0]         step_q;
	logic [39:0]        imag_q;
	logic               ineg_q;
	logic [1:0]         rstep_q;
	logic [60:0]        rprod_q;
	logic [10:0]        qh_q;
	logic [9:0]         rh_q;
	logic signed [49:0] prod_s1;
	logic [4:0]         sh_s1;
	logic               div_done;
	logic [NUM_W-1:0]   div_quo;

	logic signed [55:0] spd_num;
	logic [15:0]        ppr_eff;
	logic signed [40:0] p2;
	logic signed [25:0] ediff;
	logic signed [36:0] pd;
	logic signed [24:0] abs_t;
	logic signed [24:0] abs_s;
	logic [29:0]        rmul_a;
	logic [9:0]         rh;
	logic [30:0]        iquo;
	logic signed [42:0] q2;
	logic signed [42:0] isum;
	logic signed [42:0] lim;
	logic signed [39:0] dvm;
	logic [23:0]        gain;
	logic signed [24:0] chunk;
	logic [4:0]         sh;
	logic [15:0]        dlim;
	logic [39:0]        u;
	logic [15:0]        duty_w;

	dmsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (dnum_q),
		.den    (dden_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		spd_num = 56'(delta_q) * 56'(signed'({1'b0, RPM_SCALE}));
		ppr_eff = (cfg.pulses_per_rev == 16'd0) ? 16'd1 : cfg.pulses_per_rev;
		p2      = 41'(err_q) * 41'(signed'({1'b0, dt_q}));
		ediff   = 26'(err_q) - 26'(lerr_q);
		pd      = 37'(ediff) * 37'(signed'({1'b0, MS_PER_S}));
		abs_t   = target_q[23] ? -25'(target_q) : 25'(target_q);
		abs_s   = sp_q[23] ? -25'(sp_q) : 25'(sp_q);
		// divide |err*dt| by 1000 in two halves: high 20 bits, then remainder and low 20 bits
		rmul_a  = (rstep_q == 2'd0) ? {10'b0, imag_q[39:20]} : {rh_q, imag_q[19:0]};
		rh      = 10'(imag_q[39:20] - 20'(rprod_q[50:40]) * 20'(MS_PER_S));
		iquo    = {qh_q, rprod_q[59:40]};
		q2      = ineg_q ? -$signed({12'b0, iquo}) : $signed({12'b0, iquo});
		isum    = 43'(integ_q) + q2;
		lim     = $signed({12'b0, cfg.windup_limit});
		dvm     = $signed({1'b0, div_quo[38:0]});
	end

	// MAC operand select: each 32-bit-plus operand is split in two partial products
	always_comb begin
		case (step_q)
			3'd0: begin
				gain = cfg.prop_gain;
				chunk = err_q;
				sh = 5'd0;
			end
			3'd1: begin
				gain = cfg.integral_gain;
				chunk = $signed({9'b0, integ_q[15:0]});
				sh = 5'd0;
			end
			3'd2: begin
				gain = cfg.integral_gain;
				chunk = 25'($signed(integ_q[31:16]));
				sh = 5'd16;
			end
			3'd3: begin
				gain = cfg.deriv_gain;
				chunk = $signed({5'b0, dv_q[19:0]});
				sh = 5'd0;
			end
			3'd4: begin
				gain = cfg.deriv_gain;
				chunk = 25'($signed(dv_q[39:20]));
				sh = 5'd20;
			end
			default: begin
				gain = '0;
				chunk = '0;
				sh = 5'd0;
			end
		endcase
	end

	always_comb begin
		dlim = ({4'b0, cfg.duty_max} < DUTY_CEIL) ? {4'b0, cfg.duty_max} : DUTY_CEIL;
		u    = acc_q[63:24];
		if (acc_q[63]) begin
			duty_w = '0;
		end else if (u > {24'b0, dlim}) begin
			duty_w = dlim;
		end else begin
			duty_w = u[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_count_q <= '0;
			integ_q      <= '0;
			lerr_q       <= '0;
			div_start_q  <= 1'b0;
			step_q       <= '0;
			rstep_q      <= '0;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						last_count_q <= count;
						if (cmd.clear) begin
							integ_q <= '0;
							lerr_q  <= '0;
						end
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					div_start_q <= 1'b1;
					state_q     <= S_DSP;
				end
				S_DSP: begin
					if (div_done) begin
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					state_q <= S_PROD;
				end
				S_PROD: begin
					div_start_q <= 1'b1;
					rstep_q     <= '0;
					state_q     <= S_DINT;
				end
				S_DINT: begin
					rstep_q <= rstep_q + 1'b1;
					if (rstep_q == 2'd3) begin
						if (isum > lim) begin
							integ_q <= lim[31:0];
						end else if (isum < -lim) begin
							integ_q <= 32'(-lim);
						end else begin
							integ_q <= isum[31:0];
						end
						state_q <= S_DDER;
					end
				end
				S_DDER: begin
					if (div_done) begin
						lerr_q  <= err_q;
						step_q  <= '0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd5) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (cmd.ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd.start) begin
			delta_q  <= count - last_count_q;
			target_q <= target;
			dt_q     <= dt;
		end
		if (state_q == S_PREP) begin
			dnum_q <= spd_num[55] ? 56'(-spd_num) : 56'(spd_num);
			neg_q  <= spd_num[55];
			dden_q <= 32'(ppr_eff) * 32'(dt_q);
		end
		if (state_q == S_DSP && div_done) begin
			if (!neg_q) begin
				sp_q <= (div_quo > 56'd8388607) ? 24'sh7FFFFF : $signed(div_quo[23:0]);
			end else begin
				sp_q <= (div_quo > 56'd8388608) ? 24'sh800000 : $signed(-div_quo[23:0]);
			end
		end
		if (state_q == S_ERR) begin
			err_q <= abs_t - abs_s;
		end
		if (state_q == S_PROD) begin
			// derivative division runs while the integral step completes
			dnum_q <= pd[36] ? 56'(-pd) : 56'(pd);
			neg_q  <= pd[36];
			dden_q <= 32'(dt_q);
			imag_q <= p2[40] ? 40'(-p2) : 40'(p2);
			ineg_q <= p2[40];
		end
		if (state_q == S_DINT) begin
			case (rstep_q)
				2'd0: begin
					rprod_q <= 61'(rmul_a) * 61'(RECIP_1000);
				end
				2'd1: begin
					qh_q <= rprod_q[50:40];
					rh_q <= rh;
				end
				2'd2: begin
					rprod_q <= 61'(rmul_a) * 61'(RECIP_1000);
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_DDER && div_done) begin
			dv_q  <= neg_q ? -dvm : dvm;
			acc_q <= '0;
		end
		if (state_q == S_MAC) begin
			prod_s1 <= $signed({1'b0, gain}) * chunk;
			sh_s1   <= sh;
			if (step_q != 3'd0) begin
				acc_q <= acc_q + (64'(prod_s1) <<< sh_s1);
			end
		end
	end

	assign done  = (state_q == S_DONE);
	assign speed = sp_q;

	always_comb begin
		if (target_q == 24'sd0) begin
			dir  = DIR_COAST;
			duty = '0;
		end else begin
			dir  = target_q[23] ? DIR_REV : DIR_FWD;
			duty = duty_w[DUTY_BITS-1:0];
		end
	end

endmodule

[hdl/dual_motor_speed_pid_top.sv]
// Dual motor speed PID controller: two wheel lanes and a merging result register.
// Depends on dmsp_pkg, dmsp_lane (which uses dmsp_div).
// Each lane runs two serial divisions of 56 steps each (speed, then derivative),
// and the divide by 1000 for the integral overlaps the second one. A word is
// accepted only while no other is in flight; the next word is taken the cycle
// after the result loads, even while that result still waits downstream.
// Reset clears gains to 0, windup limit and duty max to full scale, ppr to 1,
// and all encoder baselines, integrals and previous errors to zero.
module dual_motor_speed_pid_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dmsp_pkg::IDX_W-1:0]    cfg_idx,
	input  logic [dmsp_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          tick_valid,
	output logic                          tick_stall,
	input  logic signed [31:0]            count_left,
	input  logic signed [31:0]            count_right,
	input  logic [15:0]                   elapsed_ms,
	input  logic signed [23:0]            target_left,
	input  logic signed [23:0]            target_right,
	input  logic                          clear_pid,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [dmsp_pkg::DUTY_BITS-1:0] duty_left,
	output logic [1:0]                    dir_left,
	output logic [dmsp_pkg::DUTY_BITS-1:0] duty_right,
	output logic [1:0]                    dir_right,
	output logic signed [23:0]            speed_left,
	output logic signed [23:0]            speed_right
);
	import dmsp_pkg::*;

	cfg_t      cfg_q;
	lane_cmd_t cmd;
	logic      busy_q;
	logic      res_valid_q;
	logic      accept;
	logic      load;
	logic [15:0] dt_eff;

	logic                 done_l, done_r;
	logic [DUTY_BITS-1:0] duty_l, duty_r;
	logic [1:0]           dir_l, dir_r;
	logic signed [23:0]   speed_l, speed_r;

	logic [DUTY_BITS-1:0] duty_left_q, duty_right_q;
	logic [1:0]           dir_left_q, dir_right_q;
	logic signed [23:0]   speed_left_q, speed_right_q;

	// one word in flight; stall new words until the result register is loaded
	assign tick_stall = busy_q;
	assign accept     = tick_valid && !busy_q;
	// merge: load when both lanes finish and the result register is free or being taken
	assign load       = busy_q && done_l && done_r && (!res_valid_q || !res_stall);

	// zero elapsed time counts as one millisecond
	assign dt_eff = (elapsed_ms == 16'd0) ? 16'd1 : elapsed_ms;

	assign cmd.start = accept;
	assign cmd.clear = clear_pid;
	assign cmd.ack   = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= '0;
			cfg_q.integral_gain  <= '0;
			cfg_q.deriv_gain     <= '0;
			cfg_q.windup_limit   <= 31'h7FFFFFFF;
			cfg_q.duty_max       <= 12'hFFF;
			cfg_q.pulses_per_rev <= 16'd1;
		end else if (cfg_we) begin
			// drop writes to unknown indexes
			case (cfg_idx)
				REG_PROP_GAIN:  cfg_q.prop_gain      <= cfg_data[23:0];
				REG_INT_GAIN:   cfg_q.integral_gain  <= cfg_data[23:0];
				REG_DERIV_GAIN: cfg_q.deriv_gain     <= cfg_data[23:0];
				REG_WINDUP:     cfg_q.windup_limit   <= cfg_data[30:0];
				REG_DUTY_MAX:   cfg_q.duty_max       <= cfg_data[11:0];
				REG_PPR:        cfg_q.pulses_per_rev <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	dmsp_lane u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.count  (count_left),
		.target (target_left),
		.dt     (dt_eff),
		.done   (done_l),
		.duty   (duty_l),
		.dir    (dir_l),
		.speed  (speed_l)
	);

	dmsp_lane u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.count  (count_right),
		.target (target_right),
		.dt     (dt_eff),
		.done   (done_r),
		.duty   (duty_r),
		.dir    (dir_r),
		.speed  (speed_r)
	);

	// control: busy from accept to load, result valid from load until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result word; holds while stalled since load needs a free slot
	always_ff @(posedge clk) begin
		if (load) begin
			duty_left_q   <= duty_l;
			dir_left_q    <= dir_l;
			duty_right_q  <= duty_r;
			dir_right_q   <= dir_r;
			speed_left_q  <= speed_l;
			speed_right_q <= speed_r;
		end
	end

	assign res_valid   = res_valid_q;
	assign duty_left   = duty_left_q;
	assign dir_left    = dir_left_q;
	assign duty_right  = duty_right_q;
	assign dir_right   = dir_right_q;
	assign speed_left  = speed_left_q;
	assign speed_right = speed_right_q;

endmodule

[test/testbench.sv]
// Self-checking testbench for dual_motor_speed_pid_top: directed and random ticks,
// checked against an in-bench speed and PID predictor. Depends on dmsp_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
	import dmsp_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int DOG_LIMIT   = 20000;	// cycles with no handshake at all
	localparam int SETTLE      = 250;	// longer than the block latency

	// Clock, reset and the block's ports
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic tick_valid = 1'b0;
	logic tick_stall;
	logic signed [31:0] count_left = '0, count_right = '0;
	logic [15:0] elapsed_ms = '0;
	logic signed [23:0] target_left = '0, target_right = '0;
	logic clear_pid = 1'b0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [DUTY_BITS-1:0] duty_left, duty_right;
	logic [1:0] dir_left, dir_right;
	logic signed [23:0] speed_left, speed_right;

	always #(HALF_PERIOD) clk = ~clk;

	dual_motor_speed_pid_top u_dut (.*);

	// One expected result word
	typedef struct {
		logic [DUTY_BITS-1:0] duty_l, duty_r;
		logic [1:0] dir_l, dir_r;
		logic signed [23:0] spd_l, spd_r;
	} drive_word_t;

	drive_word_t drive_q[$];

	// Predictor copy of the registers and the per-wheel state
	longint kp, ki, kd, windup, duty_cap, ppr_reg;
	logic signed [31:0] enc_base[2];
	longint integ[2], prev_err[2];

	int errors = 0;
	bit tick_took = 1'b0;
	bit quiet = 1'b0;	// no idling on either side while set
	bit hold_req = 1'b0;	// ask the receiver for a long hold-off
	int dog = 0;

	function automatic void reset_model();
		kp = 0; ki = 0; kd = 0;
		windup = 64'd2147483647; duty_cap = 4095; ppr_reg = 1;
		for (int k = 0; k < 2; k++) begin
			enc_base[k] = '0; integ[k] = 0; prev_err[k] = 0;
		end
	endfunction

	// Speed from the count delta, then PID on |target| - |speed| for one wheel
	function automatic void wheel_step(int k, logic signed [31:0] cnt,
			logic signed [23:0] tgt, longint dt, output logic [DUTY_BITS-1:0] duty,
			output logic [1:0] dir, output logic signed [23:0] spd);
		logic signed [31:0] d32;
		longint delta, sp, err, dv, sum, u, ppr, tg;
		d32 = cnt - enc_base[k];
		delta = longint'(d32);
		ppr = (ppr_reg == 0) ? 1 : ppr_reg;
		tg = longint'(tgt);
		sp = (delta * 64'sd15360000) / (ppr * dt);
		if (sp > 8388607) sp = 8388607;
		if (sp < -8388608) sp = -8388608;
		err = ((tg < 0) ? -tg : tg) - ((sp < 0) ? -sp : sp);
		integ[k] += (err * dt) / 1000;
		if (integ[k] > windup) integ[k] = windup;
		if (integ[k] < -windup) integ[k] = -windup;
		dv = ((err - prev_err[k]) * 1000) / dt;
		sum = kp * err + ki * integ[k] + kd * dv;
		if (sum < 0) begin
			u = 0;
		end else begin
			u = sum >>> 24;
			if (u > duty_cap) u = duty_cap;
			if (u > (1 << DUTY_BITS) - 1) u = (1 << DUTY_BITS) - 1;
		end
		prev_err[k] = err;
		enc_base[k] = cnt;
		spd = sp[23:0];
		if (tg > 0) begin
			dir = DIR_FWD; duty = u[DUTY_BITS-1:0];
		end else if (tg < 0) begin
			dir = DIR_REV; duty = u[DUTY_BITS-1:0];
		end else begin
			dir = DIR_COAST; duty = '0;
		end
	endfunction

	function automatic void predict_tick();
		drive_word_t w;
		longint dt;
		dt = (elapsed_ms == 0) ? 1 : longint'(elapsed_ms);
		if (clear_pid) begin
			integ[0] = 0; integ[1] = 0; prev_err[0] = 0; prev_err[1] = 0;
		end
		wheel_step(0, count_left, target_left, dt, w.duty_l, w.dir_l, w.spd_l);
		wheel_step(1, count_right, target_right, dt, w.duty_r, w.dir_r, w.spd_r);
		drive_q.push_back(w);
	endfunction

	// Flag each accepted tick word for the sender; both sides see pre-edge values
	always @(posedge clk) begin
		tick_took = tick_valid && !tick_stall;
	end

	// Compare each accepted result word against the oldest prediction
	task automatic check_field(string name, longint expv, longint act);
		if (expv != act) begin
			$error("%s expected %0d actual %0d", name, expv, act);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		drive_word_t w;
		if (arst_n && res_valid && !res_stall) begin
			if (drive_q.size() == 0) begin
				$error("result word with no tick pending");
				errors++;
			end else begin
				w = drive_q.pop_front();
				check_field("duty_left", w.duty_l, duty_left);
				check_field("dir_left", w.dir_l, dir_left);
				check_field("duty_right", w.duty_r, duty_right);
				check_field("dir_right", w.dir_r, dir_right);
				check_field("speed_left", w.spd_l, speed_left);
				check_field("speed_right", w.spd_r, speed_right);
			end
		end
	end

	// Receiver: random stalls, or a long counted hold-off on request
	always @(negedge clk) begin
		int hold;
		if (hold_req && hold == 0) begin
			hold = 800;
			hold_req = 1'b0;
		end
		if (hold > 0) begin
			hold--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= !quiet && ($urandom_range(0, 99) < 8);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((tick_valid && !tick_stall) || (res_valid && !res_stall) || cfg_we
				|| !arst_n)
			dog = 0;
		else
			dog++;
		if (dog >= DOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Send one tick word; called at a falling edge, returns at one
	task automatic send_tick(logic signed [31:0] cl, logic signed [31:0] cr,
			logic [15:0] ms, logic signed [23:0] tl, logic signed [23:0] tr, logic clr);
		while (!quiet && $urandom_range(0, 99) < 8) begin
			tick_valid = 1'b0;
			@(negedge clk);
		end
		count_left = cl; count_right = cr; elapsed_ms = ms;
		target_left = tl; target_right = tr; clear_pid = clr;
		tick_valid = 1'b1;
		do @(negedge clk); while (!tick_took);
		predict_tick();
	endtask

	// Drop valid, wait out all results, then let the block settle
	task automatic drain();
		tick_valid = 1'b0;
		while (drive_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, longint value);
		cfg_we = 1'b1; cfg_idx = idx; cfg_data = value[CFG_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_PROP_GAIN:  kp = value & 64'hFFFFFF;
			REG_INT_GAIN:   ki = value & 64'hFFFFFF;
			REG_DERIV_GAIN: kd = value & 64'hFFFFFF;
			REG_WINDUP:     windup = value & 64'h7FFFFFFF;
			REG_DUTY_MAX:   duty_cap = value & 64'hFFF;
			REG_PPR:        ppr_reg = value & 64'hFFFF;
			default: ;
		endcase
	endtask

	task automatic load_gains(longint p, longint i, longint d, longint wl, longint dm,
			longint pp);
		write_reg(REG_PROP_GAIN, p);
		write_reg(REG_INT_GAIN, i);
		write_reg(REG_DERIV_GAIN, d);
		write_reg(REG_WINDUP, wl);
		write_reg(REG_DUTY_MAX, dm);
		write_reg(REG_PPR, pp);
	endtask

	// Field extremes, zero time, coast, clear, first tick from a zero baseline
	task automatic test_directed();
		send_tick(32'sd1000, -32'sd1000, 16'd10, 24'sd25600, -24'sd25600, 1'b0);
		drain();
		load_gains(64'h10000, 64'h8000, 64'h100, 64'h7FFFFFFF, 4095, 20);
		send_tick(32'sd1200, -32'sd1100, 16'd0, 24'sh7FFFFF, 24'sh800000, 1'b0);
		send_tick(32'sh7FFFFFFF, 32'sh80000000, 16'd65535, 24'sd0, 24'sd0, 1'b0);
		send_tick(32'sh80000000, 32'sh7FFFFFFF, 16'd1, 24'sd100, -24'sd100, 1'b1);
		send_tick(32'sh80000000, 32'sh7FFFFFFF, 16'd5, 24'sd1, -24'sd1, 1'b0);
		send_tick(32'sh80000400, 32'sh7FFFF000, 16'd2, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
		drain();
		// extreme gains, tiny windup and cap, out-of-range indexes ignored
		load_gains(64'hFFFFFF, 64'hFFFFFF, 64'hFFFFFF, 0, 0, 65535);
		write_reg(3'd6, 64'h5A5A5A5A);
		write_reg(3'd7, 64'h7FFFFFFF);
		send_tick(32'sd0, 32'sd0, 16'd3, 24'sd500, -24'sd500, 1'b0);
		send_tick(32'sd65535, -32'sd65535, 16'd0, -24'sd9000, 24'sd9000, 1'b0);
		drain();
		load_gains(64'hFFFFFF, 64'hFFFFFF, 64'hFFFFFF, 64'h7FFFFFFF, 4095, 0);
		send_tick(32'sd70, -32'sd30, 16'd1, 24'sh7FFFFF, 24'sh800000, 1'b0);
		send_tick(32'sd10, 32'sd30, 16'd65535, 24'sh7FFFFF, 24'sh800000, 1'b0);
		send_tick(32'sd10, 32'sd30, 16'd7, 24'sd0, 24'sd77, 1'b1);
		drain();
	endtask

	// Random ticks: mostly smooth encoder motion, some full-range noise
	task automatic test_random(int n, int noise_pct);
		logic signed [31:0] cl, cr;
		cl = count_left; cr = count_right;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				send_tick($urandom, $urandom, 16'($urandom), 24'($urandom), 24'($urandom),
					1'($urandom));
				cl = count_left; cr = count_right;
			end else begin
				cl += $signed($urandom_range(0, 4000)) - 2000;
				cr += $signed($urandom_range(0, 4000)) - 2000;
				send_tick(cl, cr, 16'($urandom_range(0, 40)),
					24'($signed($urandom_range(0, 160000)) - 80000),
					24'($signed($urandom_range(0, 160000)) - 80000),
					$urandom_range(0, 99) < 3);
			end
		end
		drain();
	endtask

	// Receiver holds off while ticks keep coming, so the block backs up
	task automatic test_backpressure();
		hold_req = 1'b1;
		test_random(40, 10);
	endtask

	initial begin
		reset_model();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		load_gains(64'h20000, 64'h4000, 64'h80, 64'd5000000, 2000, 360);
		test_random(300, 10);
		load_gains(64'h8000, 64'h10000, 64'h0, 64'd20000, 4095, 1);
		quiet = 1'b1;
		test_random(300, 10);
		quiet = 1'b0;
		load_gains(64'h400, 64'h200, 64'h40, 64'h7FFFFFFF, 255, 1024);
		test_backpressure();
		test_random(250, 15);
		load_gains($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
			$urandom_range(0, 24'hFFFFFF), $urandom_range(0, 32'h7FFFFFFF),
			$urandom_range(0, 4095), $urandom_range(0, 65535));
		test_random(300, 30);
		repeat (SETTLE) @(negedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
